[hw/rtl/aging_event_log_ring_defines.svh]
// Assertion macros of the aging event log ring top level.
`ifndef AGING_EVENT_LOG_RING_DEFINES_SVH
`define AGING_EVENT_LOG_RING_DEFINES_SVH

// Same-cycle implication, sampled on clock and disabled while reset is high.
`define AELR_ASSERT_SAME(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("aging event log ring: same-cycle check failed");

// Next-cycle implication, sampled on clock and disabled while reset is high.
`define AELR_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("aging event log ring: next-cycle check failed");

`endif

[hw/rtl/aelr_pkg.sv]
// Shared types and constants of the aging event log ring.
`timescale 1ns / 1ps
`default_nettype none
package aelr_pkg;

   // Default store depth and fixed field widths.
   localparam int LOG_DEPTH_DEF = 1024;
   localparam int TIME_W        = 32;
   localparam int PAYLOAD_W     = 64;
   localparam int SLOT_W        = 10;
   localparam int AGE_W         = 31;

   // Command codes.
   localparam logic CMD_LOG  = 1'b0;
   localparam logic CMD_READ = 1'b1;

   // Reset value of the maximum age register.
   localparam logic [AGE_W-1:0] MAX_AGE_RESET = {AGE_W{1'b1}};

   // One stored slot; the end time is kept so pruning needs a single subtract.
   typedef struct packed {
      logic [PAYLOAD_W-1:0] payload;
      logic [TIME_W-1:0]    end_time;
      logic [TIME_W-1:0]    interval;
      logic [TIME_W-1:0]    start_time;
   } entry_type;

   // Controller states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ_RD,
      ST_READ_CAP,
      ST_PRUNE_RD,
      ST_PRUNE_CHK,
      ST_WRITE,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic rd_en;
      logic rd_slot;
      logic load_read;
      logic prune_step;
      logic write_entry;
   } ctrl_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_is_read;
      logic ring_empty;
      logic prune_hit;
   } status_type;

endpackage
`default_nettype wire

[hw/rtl/aelr_ctrl.sv]
// Controller state machine of the aging event log ring.
`timescale 1ns / 1ps
`default_nettype none
module aelr_ctrl
   import aelr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   output logic            rsp_valid,
   input  wire status_type status,
   output ctrl_type        ctrl
);

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = status.req_is_read ? ST_READ_RD : ST_PRUNE_RD;
            end
         end
         ST_READ_RD:   state_in = ST_READ_CAP;
         ST_READ_CAP:  state_in = ST_DONE;
         ST_PRUNE_RD: begin
            state_in = status.ring_empty ? ST_WRITE : ST_PRUNE_CHK;
         end
         ST_PRUNE_CHK: begin
            state_in = status.prune_hit ? ST_PRUNE_RD : ST_WRITE;
         end
         ST_WRITE:     state_in = ST_DONE;
         ST_DONE:      state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath commands.
   always_comb begin
      ctrl      = '0;
      busy      = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_DONE);
      case (state_ff)
         ST_IDLE:      ctrl.capture = start;
         ST_READ_RD: begin
            ctrl.rd_en   = 1'b1;
            ctrl.rd_slot = 1'b1;
         end
         ST_READ_CAP:  ctrl.load_read = 1'b1;
         ST_PRUNE_RD:  ctrl.rd_en = !status.ring_empty;
         ST_PRUNE_CHK: ctrl.prune_step = status.prune_hit;
         ST_WRITE:     ctrl.write_entry = 1'b1;
         ST_DONE:      ctrl = '0;
         default:      ctrl = '0;
      endcase
   end

endmodule
`default_nettype wire

[hw/rtl/aelr_datapath.sv]
// Datapath of the aging event log ring: slot store, cursors and result registers.
`timescale 1ns / 1ps
`default_nettype none
module aelr_datapath
   import aelr_pkg::*;
#(
   parameter int LOG_DEPTH = LOG_DEPTH_DEF
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire ctrl_type             ctrl,
   output status_type                status,
   input  wire logic                 req_cmd,
   input  wire logic [TIME_W-1:0]    req_now_time,
   input  wire logic [TIME_W-1:0]    req_entry_start,
   input  wire logic [TIME_W-1:0]    req_entry_interval,
   input  wire logic [PAYLOAD_W-1:0] req_entry_payload,
   input  wire logic [SLOT_W-1:0]    req_slot_index,
   input  wire logic                 csr_valid,
   input  wire logic                 csr_ready,
   input  wire logic [AGE_W-1:0]     csr_max_age,
   output logic [TIME_W-1:0]         rsp_read_start,
   output logic [TIME_W-1:0]         rsp_read_interval,
   output logic [PAYLOAD_W-1:0]      rsp_read_payload,
   output logic [SLOT_W-1:0]         rsp_head_out,
   output logic [SLOT_W-1:0]         rsp_tail_out,
   output logic [SLOT_W-1:0]         rsp_entry_count,
   output logic [SLOT_W-1:0]         rsp_pruned_count,
   output logic                      rsp_forced_drop
);

   localparam int IDX_W = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1;
   localparam int CNT_W = IDX_W + 1;
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(LOG_DEPTH - 1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(LOG_DEPTH);
   localparam logic [31:0]      DEPTH_U   = 32'(LOG_DEPTH);

   // Advance a cursor with wrap at the end of the store.
   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
      return (idx == LAST_SLOT) ? '0 : idx + 1'b1;
   endfunction

   // Slot store, one write and one registered read per cycle.
   entry_type mem [LOG_DEPTH];
   entry_type rdata_ff;
   entry_type wdata;
   logic [IDX_W-1:0] rd_addr;

   // Command fields latched at transfer.
   logic [TIME_W-1:0]    now_ff;
   logic [TIME_W-1:0]    start_ff;
   logic [TIME_W-1:0]    interval_ff;
   logic [PAYLOAD_W-1:0] payload_ff;
   logic [SLOT_W-1:0]    slot_ff;

   // Cursors, configuration and result registers.
   logic [IDX_W-1:0]  head_ff, head_in;
   logic [IDX_W-1:0]  tail_ff, tail_in;
   logic [AGE_W-1:0]  max_age_ff;
   logic [SLOT_W-1:0] pruned_ff, pruned_in;
   logic              forced_ff, forced_in;
   logic [TIME_W-1:0]    rd_start_ff;
   logic [TIME_W-1:0]    rd_interval_ff;
   logic [PAYLOAD_W-1:0] rd_payload_ff;

   logic [IDX_W-1:0]  head_next;
   logic [TIME_W-1:0] age;
   logic              slot_ok;
   logic [CNT_W-1:0]  held;

   // Latch the command on transfer.
   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         now_ff      <= req_now_time;
         start_ff    <= req_entry_start;
         interval_ff <= req_entry_interval;
         payload_ff  <= req_entry_payload;
         slot_ff     <= req_slot_index;
      end
   end

   // Store write at head and registered read.
   assign wdata.start_time = start_ff;
   assign wdata.interval   = interval_ff;
   assign wdata.end_time   = start_ff + interval_ff;
   assign wdata.payload    = payload_ff;
   assign rd_addr = ctrl.rd_slot ? IDX_W'(slot_ff) : tail_ff;

   always_ff @(posedge clock) begin
      if (ctrl.write_entry) begin
         mem[head_ff] <= wdata;
      end
      if (ctrl.rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // Signed age of the oldest entry against the configured limit.
   assign age = now_ff - rdata_ff.end_time;

   assign status.req_is_read = (req_cmd == CMD_READ);
   assign status.ring_empty  = (head_ff == tail_ff);
   assign status.prune_hit   = !age[TIME_W-1] && (age[AGE_W-1:0] > max_age_ff);

   // Cursor and counter updates.
   assign head_next = next_slot(head_ff);

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      pruned_in = pruned_ff;
      forced_in = forced_ff;
      if (ctrl.capture) begin
         pruned_in = '0;
         forced_in = 1'b0;
      end
      if (ctrl.prune_step) begin
         tail_in   = next_slot(tail_ff);
         pruned_in = pruned_ff + 1'b1;
      end
      if (ctrl.write_entry) begin
         head_in = head_next;
         // A full log loses its oldest entry.
         if (head_next == tail_ff) begin
            tail_in   = next_slot(tail_ff);
            forced_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff    <= '0;
         tail_ff    <= '0;
         pruned_ff  <= '0;
         forced_ff  <= 1'b0;
         max_age_ff <= MAX_AGE_RESET;
      end else begin
         head_ff   <= head_in;
         tail_ff   <= tail_in;
         pruned_ff <= pruned_in;
         forced_ff <= forced_in;
         if (csr_valid && csr_ready) begin
            max_age_ff <= csr_max_age;
         end
      end
   end

   // Read result fields: zero on log and for slots beyond the store.
   assign slot_ok = (32'(slot_ff) < DEPTH_U);

   always_ff @(posedge clock) begin
      if (ctrl.capture) begin
         rd_start_ff    <= '0;
         rd_interval_ff <= '0;
         rd_payload_ff  <= '0;
      end else if (ctrl.load_read && slot_ok) begin
         rd_start_ff    <= rdata_ff.start_time;
         rd_interval_ff <= rdata_ff.interval;
         rd_payload_ff  <= rdata_ff.payload;
      end
   end

   // Held entries, modulo the store depth.
   always_comb begin
      held = {1'b0, head_ff} - {1'b0, tail_ff};
      if (head_ff < tail_ff) begin
         held = held + DEPTH_CNT;
      end
   end

   assign rsp_read_start    = rd_start_ff;
   assign rsp_read_interval = rd_interval_ff;
   assign rsp_read_payload  = rd_payload_ff;
   assign rsp_head_out      = SLOT_W'(head_ff);
   assign rsp_tail_out      = SLOT_W'(tail_ff);
   assign rsp_entry_count   = SLOT_W'(held);
   assign rsp_pruned_count  = pruned_ff;
   assign rsp_forced_drop   = forced_ff;

endmodule
`default_nettype wire

[hw/rtl/aging_event_log_ring.sv]
// Top level of the aging event log ring: controller, datapath and checks.
//
// Usage: a command is transferred at a rising edge with start high and busy
// low. req_cmd selects log (append one timed entry) or read (return the slot
// at req_slot_index). Exactly one result follows per command, shown for one
// cycle with rsp_valid high; the receiver cannot hold it off.
// Sequence after the transfer edge:
//   read: the slot is read from the store, the result fields are loaded,
//         then rsp_valid; the next command is taken once busy is low.
//   log:  the tail entry is read, checked and dropped while it is too old,
//         until the log is empty or an entry is kept; then the new entry
//         is written and rsp_valid follows, and busy drops after it.
// Each pruning step costs one read of the store's read port and one compare.
// Configuration: csr_max_age is written when csr_valid and csr_ready are both
// high; csr_ready is always high. Write it only while busy is low.
// Reset clears head, tail and the result flags and sets max_age to all ones.
// The slot store is not cleared; the user must read back only written slots (not enforced).
`timescale 1ns / 1ps
`default_nettype none
`include "aging_event_log_ring_defines.svh"
module aging_event_log_ring
   import aelr_pkg::*;
#(
   parameter int LOG_DEPTH = LOG_DEPTH_DEF
)
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output logic                      busy,
   input  wire logic                 req_cmd,
   input  wire logic [TIME_W-1:0]    req_now_time,
   input  wire logic [TIME_W-1:0]    req_entry_start,
   input  wire logic [TIME_W-1:0]    req_entry_interval,
   input  wire logic [PAYLOAD_W-1:0] req_entry_payload,
   input  wire logic [SLOT_W-1:0]    req_slot_index,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [AGE_W-1:0]     csr_max_age,
   output logic                      rsp_valid,
   output logic [TIME_W-1:0]         rsp_read_start,
   output logic [TIME_W-1:0]         rsp_read_interval,
   output logic [PAYLOAD_W-1:0]      rsp_read_payload,
   output logic [SLOT_W-1:0]         rsp_head_out,
   output logic [SLOT_W-1:0]         rsp_tail_out,
   output logic [SLOT_W-1:0]         rsp_entry_count,
   output logic [SLOT_W-1:0]         rsp_pruned_count,
   output logic                      rsp_forced_drop
);

   localparam logic [SLOT_W-1:0] FULL_COUNT = SLOT_W'(LOG_DEPTH - 1);

   ctrl_type   ctrl;
   status_type status;

   // The register port never stalls a transfer.
   assign csr_ready = 1'b1;

   aelr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .status    (status),
      .ctrl      (ctrl)
   );

   aelr_datapath #(
      .LOG_DEPTH (LOG_DEPTH)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .ctrl               (ctrl),
      .status             (status),
      .req_cmd            (req_cmd),
      .req_now_time       (req_now_time),
      .req_entry_start    (req_entry_start),
      .req_entry_interval (req_entry_interval),
      .req_entry_payload  (req_entry_payload),
      .req_slot_index     (req_slot_index),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_max_age        (csr_max_age),
      .rsp_read_start     (rsp_read_start),
      .rsp_read_interval  (rsp_read_interval),
      .rsp_read_payload   (rsp_read_payload),
      .rsp_head_out       (rsp_head_out),
      .rsp_tail_out       (rsp_tail_out),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_pruned_count   (rsp_pruned_count),
      .rsp_forced_drop    (rsp_forced_drop)
   );

   // A transferred command keeps the block busy until its result is out.
   `AELR_ASSERT_NEXT(a_busy_after_start, start && !busy, busy)
   // The result strobe lasts exactly one cycle.
   `AELR_ASSERT_NEXT(a_strobe_single, rsp_valid, !rsp_valid && !busy)
   // A forced drop leaves the log exactly full.
   `AELR_ASSERT_SAME(a_forced_full, rsp_valid && rsp_forced_drop, rsp_entry_count == FULL_COUNT)
   // The result strobe only shows while a command is in progress.
   `AELR_ASSERT_SAME(a_strobe_busy, rsp_valid, busy)

endmodule
`default_nettype wire

[dv/aging_event_log_ring_test.sv]
// Self-checking testbench for the aging event log ring: stimulus, prediction and checks.
`timescale 1ns / 1ps
module aging_event_log_ring_test;
   import aelr_pkg::*;

   // One command as presented on the request ports.
   typedef struct packed {
      logic                 cmd;
      logic [TIME_W-1:0]    now_time;
      logic [TIME_W-1:0]    entry_start;
      logic [TIME_W-1:0]    entry_interval;
      logic [PAYLOAD_W-1:0] entry_payload;
      logic [SLOT_W-1:0]    slot_index;
   } log_command_type;

   // One result; the field order follows the response ports.
   typedef struct packed {
      logic [TIME_W-1:0]    read_start;
      logic [TIME_W-1:0]    read_interval;
      logic [PAYLOAD_W-1:0] read_payload;
      logic [SLOT_W-1:0]    head_out;
      logic [SLOT_W-1:0]    tail_out;
      logic [SLOT_W-1:0]    entry_count;
      logic [SLOT_W-1:0]    pruned_count;
      logic                 forced_drop;
   } log_status_type;

   // Shadow copy of the ring plus the queue of results still owed by the block.
   class log_ring_scoreboard;
      logic [TIME_W-1:0]    start_mem [LOG_DEPTH_DEF];
      logic [TIME_W-1:0]    interval_mem [LOG_DEPTH_DEF];
      logic [PAYLOAD_W-1:0] payload_mem [LOG_DEPTH_DEF];
      bit                   slot_written [LOG_DEPTH_DEF];
      int                   head_idx;
      int                   tail_idx;
      logic [AGE_W-1:0]     max_age;
      log_status_type       status_q [$];
      int                   mismatches;

      function new();
         head_idx   = 0;
         tail_idx   = 0;
         max_age    = MAX_AGE_RESET;
         mismatches = 0;
         foreach (slot_written[i]) slot_written[i] = 1'b0;
      endfunction

      function int held();
         if (head_idx >= tail_idx) return head_idx - tail_idx;
         return LOG_DEPTH_DEF - (tail_idx - head_idx);
      endfunction

      function int next_slot(int i);
         return (i + 1 == LOG_DEPTH_DEF) ? 0 : i + 1;
      endfunction

      // An entry is stale when its signed age is strictly above max_age.
      function bit is_stale(logic [TIME_W-1:0] now, int i);
         logic [TIME_W-1:0] age;
         age = now - (start_mem[i] + interval_mem[i]);
         return $signed(age) > $signed({1'b0, max_age});
      endfunction

      // Picks a slot that has been written: newest, oldest or any.
      function logic [SLOT_W-1:0] pick_read_slot();
         int s;
         int choice;
         choice = $urandom_range(0, 3);
         if (choice == 0) begin
            s = (head_idx == 0) ? LOG_DEPTH_DEF - 1 : head_idx - 1;
         end else if (choice == 1 && held() != 0) begin
            s = tail_idx;
         end else begin
            do s = $urandom_range(0, LOG_DEPTH_DEF - 1); while (!slot_written[s]);
         end
         return SLOT_W'(s);
      endfunction

      // Advances the shadow ring by one accepted command and queues its result.
      function void note_command(log_command_type c);
         log_status_type s;
         s = '0;
         if (c.cmd == CMD_READ) begin
            s.read_start    = start_mem[c.slot_index];
            s.read_interval = interval_mem[c.slot_index];
            s.read_payload  = payload_mem[c.slot_index];
         end else begin
            while (tail_idx != head_idx && is_stale(c.now_time, tail_idx)) begin
               tail_idx       = next_slot(tail_idx);
               s.pruned_count = s.pruned_count + 1'b1;
            end
            start_mem[head_idx]    = c.entry_start;
            interval_mem[head_idx] = c.entry_interval;
            payload_mem[head_idx]  = c.entry_payload;
            slot_written[head_idx] = 1'b1;
            head_idx               = next_slot(head_idx);
            // A full ring loses its oldest entry.
            if (head_idx == tail_idx) begin
               tail_idx      = next_slot(tail_idx);
               s.forced_drop = 1'b1;
            end
         end
         s.head_out    = SLOT_W'(head_idx);
         s.tail_out    = SLOT_W'(tail_idx);
         s.entry_count = SLOT_W'(held());
         status_q.push_back(s);
      endfunction

      task report_mismatch(string msg);
         $display("%0t ns: mismatch: %s", $time, msg);
         mismatches++;
      endtask

      task compare_field(string name, logic [63:0] got, logic [63:0] want);
         if (got !== want)
            report_mismatch($sformatf("%s got %h, expected %h", name, got, want));
      endtask

      // Compares one transferred result against the oldest expectation.
      task check_result(log_status_type got);
         log_status_type want;
         if (status_q.size() == 0) begin
            report_mismatch("result with no command outstanding");
            return;
         end
         want = status_q.pop_front();
         compare_field("read_start", got.read_start, want.read_start);
         compare_field("read_interval", got.read_interval, want.read_interval);
         compare_field("read_payload", got.read_payload, want.read_payload);
         compare_field("head_out", got.head_out, want.head_out);
         compare_field("tail_out", got.tail_out, want.tail_out);
         compare_field("entry_count", got.entry_count, want.entry_count);
         compare_field("pruned_count", got.pruned_count, want.pruned_count);
         compare_field("forced_drop", got.forced_drop, want.forced_drop);
      endtask
   endclass

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic                 req_cmd;
   logic [TIME_W-1:0]    req_now_time;
   logic [TIME_W-1:0]    req_entry_start;
   logic [TIME_W-1:0]    req_entry_interval;
   logic [PAYLOAD_W-1:0] req_entry_payload;
   logic [SLOT_W-1:0]    req_slot_index;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [AGE_W-1:0]     csr_max_age;
   logic                 rsp_valid;
   logic [TIME_W-1:0]    rsp_read_start;
   logic [TIME_W-1:0]    rsp_read_interval;
   logic [PAYLOAD_W-1:0] rsp_read_payload;
   logic [SLOT_W-1:0]    rsp_head_out;
   logic [SLOT_W-1:0]    rsp_tail_out;
   logic [SLOT_W-1:0]    rsp_entry_count;
   logic [SLOT_W-1:0]    rsp_pruned_count;
   logic                 rsp_forced_drop;

   log_ring_scoreboard log_sb = new();
   logic [TIME_W-1:0]  sim_now;

   aging_event_log_ring dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_cmd            (req_cmd),
      .req_now_time       (req_now_time),
      .req_entry_start    (req_entry_start),
      .req_entry_interval (req_entry_interval),
      .req_entry_payload  (req_entry_payload),
      .req_slot_index     (req_slot_index),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_max_age        (csr_max_age),
      .rsp_valid          (rsp_valid),
      .rsp_read_start     (rsp_read_start),
      .rsp_read_interval  (rsp_read_interval),
      .rsp_read_payload   (rsp_read_payload),
      .rsp_head_out       (rsp_head_out),
      .rsp_tail_out       (rsp_tail_out),
      .rsp_entry_count    (rsp_entry_count),
      .rsp_pruned_count   (rsp_pruned_count),
      .rsp_forced_drop    (rsp_forced_drop)
   );

   // Free-running clock.
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Run limit, far above the slowest correct run.
   initial begin
      #12_000_000;
      $display("FAILURE");
      $finish;
   end

   // Every cycle with rsp_valid high is one result transfer.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         log_sb.check_result(log_status_type'({rsp_read_start, rsp_read_interval,
            rsp_read_payload, rsp_head_out, rsp_tail_out, rsp_entry_count,
            rsp_pruned_count, rsp_forced_drop}));
   end

   function automatic log_command_type log_entry(logic [TIME_W-1:0] now,
         logic [TIME_W-1:0] first, logic [TIME_W-1:0] span, logic [PAYLOAD_W-1:0] data);
      log_command_type c;
      c.cmd            = CMD_LOG;
      c.now_time       = now;
      c.entry_start    = first;
      c.entry_interval = span;
      c.entry_payload  = data;
      c.slot_index     = SLOT_W'($urandom);
      return c;
   endfunction

   function automatic log_command_type read_slot(logic [SLOT_W-1:0] slot);
      log_command_type c;
      c = log_entry($urandom, $urandom, $urandom, {$urandom, $urandom});
      c.cmd        = CMD_READ;
      c.slot_index = slot;
      return c;
   endfunction

   // Random command. In aging mode, time moves forward in steps scaled to
   // max_age so entries grow stale a few at a time; some items stay pure noise.
   function automatic log_command_type random_command(int read_pct, bit aging);
      log_command_type c;
      int unsigned     span;
      c = log_entry($urandom, $urandom, $urandom, {$urandom, $urandom});
      if ($urandom_range(0, 99) < read_pct) begin
         c.cmd        = CMD_READ;
         c.slot_index = log_sb.pick_read_slot();
      end else if (aging && $urandom_range(0, 9) != 0) begin
         span = (log_sb.max_age >> 2) + 1;
         if ($urandom_range(0, 99) < 3)
            sim_now = sim_now + TIME_W'(log_sb.max_age) + $urandom_range(1, span);
         else
            sim_now = sim_now + $urandom_range(0, span);
         c.now_time       = sim_now;
         c.entry_start    = sim_now - $urandom_range(0, span);
         c.entry_interval = $urandom_range(0, span);
      end
      return c;
   endfunction

   // Mostly short gaps, a few long ones, and quiet stretches with none.
   function automatic int gap_cycles(int k);
      int r;
      if ((k / 64) % 4 == 3) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Presents one command and holds it until the block takes the transfer.
   task automatic send_command(log_command_type c);
      start              <= 1'b1;
      req_cmd            <= c.cmd;
      req_now_time       <= c.now_time;
      req_entry_start    <= c.entry_start;
      req_entry_interval <= c.entry_interval;
      req_entry_payload  <= c.entry_payload;
      req_slot_index     <= c.slot_index;
      do @(posedge clock); while (busy !== 1'b0);
      log_sb.note_command(c);
   endtask

   task automatic idle_after(int k);
      int g;
      g = gap_cycles(k);
      if (g != 0) begin
         start <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   // Stops sending until every owed result has come back.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (log_sb.status_q.size() != 0 || busy !== 1'b0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_max_age(logic [AGE_W-1:0] value);
      csr_valid   <= 1'b1;
      csr_max_age <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid   <= 1'b0;
      log_sb.max_age = value;
   endtask

   task automatic run_random(int n, int read_pct, bit aging);
      for (int k = 0; k < n; k++) begin
         send_command(random_command(read_pct, aging));
         idle_after(k);
         if (k == n / 2) drain();
      end
   endtask

   initial begin
      logic [AGE_W-1:0] age_settings [5];
      age_settings[0] = AGE_W'($urandom_range(1, 2000));
      age_settings[1] = '0;
      age_settings[2] = AGE_W'($urandom);
      age_settings[3] = 1;
      age_settings[4] = AGE_W'($urandom_range(2, 100));
      sim_now            = $urandom;
      reset              <= 1'b1;
      start              <= 1'b0;
      req_cmd            <= CMD_LOG;
      req_now_time       <= '0;
      req_entry_start    <= '0;
      req_entry_interval <= '0;
      req_entry_payload  <= '0;
      req_slot_index     <= '0;
      csr_valid          <= 1'b0;
      csr_max_age        <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Field extremes under the reset max_age, which never prunes.
      send_command(log_entry('0, '0, '0, '0));
      idle_after(0);
      send_command(log_entry('1, '1, '1, '1));
      send_command(read_slot(0));
      send_command(read_slot(1));
      idle_after(1);
      send_command(log_entry('0, 32'h8000_0000, '0, 64'h5555_aaaa_5555_aaaa));
      send_command(read_slot(2));
      drain();

      // Zero max_age: equal age kept, several pruned at once, a negative age
      // stops pruning, and a wrapped end time.
      write_max_age('0);
      send_command(log_entry('0, 32'h10, '0, 64'h0123_4567_89ab_cdef));
      send_command(log_entry(32'h1, 32'h1, '0, 64'hfedc_ba98_7654_3210));
      idle_after(2);
      send_command(log_entry(32'h10, 32'hffff_fff0, 32'h20, 64'h8000_0000_0000_0001));
      send_command(log_entry(32'h9000_0000, 32'h9000_0000, '0, 64'h7fff_ffff_ffff_fffe));
      send_command(log_entry(32'h9000_0000, 32'h8fff_ffff, 32'h1, 64'h1));
      send_command(read_slot(5));
      send_command(read_slot(6));
      drain();

      // Largest max_age: a tail entry of positive age is kept, and the random
      // run that follows never prunes.
      write_max_age('1);
      send_command(log_entry(32'h0fff_ffff, '0, '0, {$urandom, $urandom}));
      run_random(300, 6, 1'b0);

      // Entries age out under a series of max_age settings.
      foreach (age_settings[i]) begin
         drain();
         write_max_age(age_settings[i]);
         run_random(115, 15, 1'b1);
      end

      start <= 1'b0;
      for (int w = 0; w < 5000 && log_sb.status_q.size() != 0; w++) @(posedge clock);
      if (log_sb.status_q.size() != 0)
         log_sb.report_mismatch("commands still without a result at the end");
      repeat (20) @(posedge clock);
      if (log_sb.mismatches == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule
